[hdl/ndrm_pkg.sv]
// ----------------------------------------------------------------------------
// ndrm_pkg
// Shared types and constants of the nearest delta-R charge matcher.
// ----------------------------------------------------------------------------
package ndrm_pkg;

	// Fixed point: eta and phi carry FRAC_BITS fraction bits.
	localparam int FRAC_BITS = 12;

	localparam longint PI_Q_L     = (205887 * (longint'(1) << FRAC_BITS) + 32768) >>> 16;
	localparam longint DIST_MAX_L = 64'h7FFF_FFFF;
	localparam longint NINE_RAW_L = longint'(81) << (2 * FRAC_BITS);
	localparam longint NINE_SQ_L  = (NINE_RAW_L > DIST_MAX_L) ? DIST_MAX_L : NINE_RAW_L;

	localparam logic signed [16:0] PI_Q     = 17'(PI_Q_L);
	localparam logic signed [16:0] NEG_PI_Q = -17'(PI_Q_L);
	localparam logic signed [16:0] TWO_PI_Q = 17'(2 * PI_Q_L);
	localparam logic [30:0]        DIST_MAX = 31'(DIST_MAX_L);
	localparam logic [30:0]        NINE_SQ  = 31'(NINE_SQ_L);

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_LEPTON_ID      = 2'd0,
		REG_SKIP_ENABLE    = 2'd1,
		REG_MIN_DECAY_MODE = 2'd2
	} reg_index_t;

	// Classification made by the front part
	typedef enum logic [1:0] {
		KIND_RECO = 2'd0,
		KIND_GEN  = 2'd1,
		KIND_SKIP = 2'd2
	} item_kind_t;

	typedef struct packed {
		logic [6:0]        lepton_id;
		logic              skip_enable;
		logic signed [4:0] min_decay_mode;
	} cfg_t;

	// charge holds the reco charge for reco items and the running charge for gen items
	typedef struct packed {
		item_kind_t         kind;
		logic signed [15:0] eta;
		logic signed [14:0] phi;
		logic signed [1:0]  charge;
		logic               last;
	} queue_item_t;

	typedef struct packed {
		logic        valid;
		queue_item_t item;
	} queue_port_t;

endpackage

[hdl/ndrm_front.sv]
// ----------------------------------------------------------------------------
// ndrm_front
// Accepts requests, classifies them and tracks the running gen charge.
// ----------------------------------------------------------------------------
module ndrm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ndrm_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	input  logic                 req_type,
	input  logic signed [15:0]   eta,
	input  logic signed [14:0]   phi,
	input  logic signed [7:0]    id_code,
	input  logic signed [4:0]    decay_mode,
	input  logic                 last,
	input  logic                 queue_full,
	output logic                 in_ready,
	output ndrm_pkg::queue_port_t push
);
	import ndrm_pkg::*;

	logic signed [1:0] running_q;
	logic signed [1:0] running_nxt;
	logic signed [1:0] reco_charge;
	logic signed [7:0] lid_pos;
	logic signed [7:0] lid_neg;
	logic              skip;
	logic              accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	assign lid_pos = $signed({1'b0, cfg.lepton_id});
	assign lid_neg = 8'sd0 - lid_pos;
	assign skip    = cfg.skip_enable && (decay_mode < cfg.min_decay_mode);

	// Any code other than -1, 0 or +1 is kept as -2, which no gen charge equals.
	always_comb begin
		if (id_code == 8'sd1 || id_code == 8'sd0 || id_code == -8'sd1) begin
			reco_charge = id_code[1:0];
		end else begin
			reco_charge = -2'sd2;
		end
	end

	// The negative id check comes second, so a lepton id of zero gives +1.
	always_comb begin
		running_nxt = running_q;
		if (id_code == lid_pos) begin
			running_nxt = -2'sd1;
		end
		if (id_code == lid_neg) begin
			running_nxt = 2'sd1;
		end
	end

	always_comb begin
		push.item.eta  = eta;
		push.item.phi  = phi;
		push.item.last = last;
		if (!req_type) begin
			push.valid       = accept;
			push.item.kind   = KIND_RECO;
			push.item.charge = reco_charge;
		end else if (skip) begin
			// A skipped item only travels on when it has to release a result.
			push.valid       = accept && last;
			push.item.kind   = KIND_SKIP;
			push.item.charge = running_q;
		end else begin
			push.valid       = accept;
			push.item.kind   = KIND_GEN;
			push.item.charge = running_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 2'sd0;
		end else if (accept) begin
			if (!req_type) begin
				running_q <= 2'sd0;
			end else if (!skip) begin
				running_q <= running_nxt;
			end
		end
	end

endmodule

[hdl/ndrm_queue.sv]
// ----------------------------------------------------------------------------
// ndrm_queue
// Short first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
module ndrm_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ndrm_pkg::queue_port_t push,
	output logic                  full,
	input  logic                  pop,
	output ndrm_pkg::queue_port_t head
);
	import ndrm_pkg::*;

	queue_item_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]     wr_ptr_q;
	logic [QUEUE_AW-1:0]     rd_ptr_q;
	logic [QUEUE_AW:0]       count_q;
	logic                    do_push;
	logic                    do_pop;

	assign full       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/ndrm_back.sv]
// ----------------------------------------------------------------------------
// ndrm_back
// Distance pipeline, best-match tracking and result register.
// ----------------------------------------------------------------------------
module ndrm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ndrm_pkg::queue_port_t head,
	output logic                  pop,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [30:0]           dist_sq,
	output logic                  charge_mismatch
);
	import ndrm_pkg::*;

	logic               en;

	// Stage 1: differences and phi wrap
	logic               v_s1;
	item_kind_t         kind_s1;
	logic signed [1:0]  charge_s1;
	logic               last_s1;
	logic signed [16:0] deta_s1;
	logic signed [16:0] dphi_s1;
	logic signed [15:0] reco_eta_q;
	logic signed [14:0] reco_phi_q;
	logic signed [16:0] deta;
	logic signed [16:0] dphi_raw;
	logic signed [16:0] dphi;

	// Stage 2: squares
	logic               v_s2;
	item_kind_t         kind_s2;
	logic signed [1:0]  charge_s2;
	logic               last_s2;
	logic [31:0]        sq_eta_s2;
	logic [31:0]        sq_phi_s2;
	logic signed [33:0] prod_eta;
	logic signed [33:0] prod_phi;

	// Stage 3: saturated sum
	logic               v_s3;
	item_kind_t         kind_s3;
	logic signed [1:0]  charge_s3;
	logic               last_s3;
	logic [30:0]        dist_s3;
	logic [32:0]        sum;

	// Match state and result
	logic [30:0]        best_q;
	logic signed [1:0]  best_charge_q;
	logic signed [1:0]  reco_charge_q;
	logic [30:0]        best_nxt;
	logic signed [1:0]  best_charge_nxt;
	logic signed [1:0]  reco_charge_nxt;
	logic               res_valid_q;
	logic [30:0]        dist_q;
	logic               mismatch_q;

	// The whole pipeline moves whenever the result register can take a new value.
	assign en  = !res_valid_q || res_ready;
	assign pop = en && head.valid;

	assign deta     = {head.item.eta[15], head.item.eta} - {reco_eta_q[15], reco_eta_q};
	assign dphi_raw = {head.item.phi[14], head.item.phi[14], head.item.phi}
		- {reco_phi_q[14], reco_phi_q[14], reco_phi_q};

	always_comb begin
		if (dphi_raw >= PI_Q) begin
			dphi = dphi_raw - TWO_PI_Q;
		end else if (dphi_raw < NEG_PI_Q) begin
			dphi = dphi_raw + TWO_PI_Q;
		end else begin
			dphi = dphi_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			reco_eta_q <= '0;
			reco_phi_q <= '0;
		end else if (en) begin
			v_s1 <= head.valid;
			if (head.valid && head.item.kind == KIND_RECO) begin
				reco_eta_q <= head.item.eta;
				reco_phi_q <= head.item.phi;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1   <= head.item.kind;
			charge_s1 <= head.item.charge;
			last_s1   <= head.item.last;
			deta_s1   <= deta;
			dphi_s1   <= dphi;
		end
	end

	assign prod_eta = $signed({{17{deta_s1[16]}}, deta_s1}) * $signed({{17{deta_s1[16]}}, deta_s1});
	assign prod_phi = $signed({{17{dphi_s1[16]}}, dphi_s1}) * $signed({{17{dphi_s1[16]}}, dphi_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Both squares stay below 2^32, so the low 32 bits carry the full value.
	assign sum = {1'b0, sq_eta_s2} + {1'b0, sq_phi_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2   <= kind_s1;
			charge_s2 <= charge_s1;
			last_s2   <= last_s1;
			sq_eta_s2 <= prod_eta[31:0];
			sq_phi_s2 <= prod_phi[31:0];
			kind_s3   <= kind_s2;
			charge_s3 <= charge_s2;
			last_s3   <= last_s2;
			dist_s3   <= (sum > {2'b00, DIST_MAX}) ? DIST_MAX : sum[30:0];
		end
	end

	always_comb begin
		best_nxt        = best_q;
		best_charge_nxt = best_charge_q;
		reco_charge_nxt = reco_charge_q;
		if (v_s3) begin
			unique case (kind_s3)
				KIND_RECO: begin
					best_nxt        = NINE_SQ;
					best_charge_nxt = 2'sd0;
					reco_charge_nxt = charge_s3;
				end
				KIND_GEN: begin
					if (dist_s3 < best_q) begin
						best_nxt        = dist_s3;
						best_charge_nxt = charge_s3;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q        <= NINE_SQ;
			best_charge_q <= 2'sd0;
			reco_charge_q <= 2'sd0;
			res_valid_q   <= 1'b0;
		end else if (en) begin
			best_q        <= best_nxt;
			best_charge_q <= best_charge_nxt;
			reco_charge_q <= reco_charge_nxt;
			res_valid_q   <= v_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_q     <= best_nxt;
			mismatch_q <= (reco_charge_nxt != best_charge_nxt);
		end
	end

	assign res_valid       = res_valid_q;
	assign dist_sq         = dist_q;
	assign charge_mismatch = mismatch_q;

endmodule

[hdl/nearest_delta_r_charge_matcher_unit.sv]
// ----------------------------------------------------------------------------
// nearest_delta_r_charge_matcher_unit
// Nearest delta-R matcher of one reco particle against gen candidates.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the queue has room; the back pipeline
// advances every cycle in which the result register is empty or being taken.
// Path: the request with tlast passes the queue, the difference, square and sum
// stages and the compare into the result register, and waits under backpressure.
// Reset: arst_n clears the queue, pipeline valids, match state, result valid and
// configuration registers to their reset values at once; no clearing pass is needed.
module nearest_delta_r_charge_matcher_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // eta[15:0], phi[30:16], id_code[38:31], decay_mode[43:39], zero
	input  logic        s_tuser,   // req_type
	input  logic        s_tlast,   // last
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // dist_sq[30:0], charge_mismatch[31]
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ndrm_pkg::*;

	cfg_t        cfg_q;
	reg_index_t  reg_idx;
	logic        cfg_write;
	queue_port_t push;
	queue_port_t head;
	logic        queue_full;
	logic        pop;
	logic [30:0] dist_sq;
	logic        charge_mismatch;

	assign pready    = 1'b1;
	assign reg_idx   = reg_index_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lepton_id      <= 7'd15;
			cfg_q.skip_enable    <= 1'b1;
			cfg_q.min_decay_mode <= 5'sd3;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_LEPTON_ID:      cfg_q.lepton_id      <= pwdata[6:0];
				REG_SKIP_ENABLE:    cfg_q.skip_enable    <= pwdata[0];
				REG_MIN_DECAY_MODE: cfg_q.min_decay_mode <= pwdata[4:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LEPTON_ID:      prdata = {25'd0, cfg_q.lepton_id};
			REG_SKIP_ENABLE:    prdata = {31'd0, cfg_q.skip_enable};
			REG_MIN_DECAY_MODE: prdata = {27'd0, cfg_q.min_decay_mode};
			default:            prdata = '0;
		endcase
	end

	ndrm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.req_type   (s_tuser),
		.eta        (s_tdata[15:0]),
		.phi        (s_tdata[30:16]),
		.id_code    (s_tdata[38:31]),
		.decay_mode (s_tdata[43:39]),
		.last       (s_tlast),
		.queue_full (queue_full),
		.in_ready   (s_tready),
		.push       (push)
	);

	ndrm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.pop    (pop),
		.head   (head)
	);

	ndrm_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.pop             (pop),
		.res_valid       (m_tvalid),
		.res_ready       (m_tready),
		.dist_sq         (dist_sq),
		.charge_mismatch (charge_mismatch)
	);

	assign m_tdata = {charge_mismatch, dist_sq};

endmodule

[hdl/ndrm_checker.sv]
// ----------------------------------------------------------------------------
// ndrm_checker
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
module ndrm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        psel,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [31:0] prdata,
	input logic        pready
);
	import ndrm_pkg::*;

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The best distance never exceeds its starting value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[30:0] <= NINE_SQ)
		else $error("result distance above nine squared");

	// The configuration port never inserts wait states.
	assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

	// The skip enable register reads back as a single bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && paddr[3:2] == REG_SKIP_ENABLE |-> prdata[31:1] == 31'd0)
		else $error("skip enable read back with extra bits");

endmodule

bind nearest_delta_r_charge_matcher_unit ndrm_checker u_ndrm_checker (.*);

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest delta-R charge matcher.
// A short table of directed requests covers the field extremes, the phi wrap,
// saturation, skipping and the charge rules. Random matches follow under
// several register settings and flow-control patterns. A behavioural model of
// the matcher predicts every result not given in the table; all are checked in order.
// ----------------------------------------------------------------------------
module tb;
	import ndrm_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASE_ITEMS   = 80;
	localparam int SETTLE_CYCLES = 8;
	localparam int NINE          = int'(NINE_SQ);
	localparam int PI_I          = int'(PI_Q);
	localparam int TWO_PI_I      = int'(TWO_PI_Q);

	typedef struct packed {
		logic               req_type;
		logic signed [15:0] eta;
		logic signed [14:0] phi;
		logic signed [7:0]  id_code;
		logic signed [4:0]  decay_mode;
		logic               last;
	} match_req_t;

	typedef struct packed {
		logic [30:0] dist_sq;
		logic        charge_mismatch;
	} match_res_t;

	typedef struct packed {
		bit         wr;
		reg_index_t wr_reg;
		int         wr_val;
		bit         req_type;
		int         eta;
		int         phi;
		int         id_code;
		int         decay_mode;
		bit         last;
		bit         typed;
		int         dist_sq;
		bit         charge_mismatch;
	} dir_row_t;

	typedef struct packed {
		int lid;
		int skip;
		int min_dm;
	} reg_set_t;

	// Directed requests; rows marked typed carry their result, the rest use the model.
	localparam dir_row_t DIR_ROWS [19] = '{
		'{1'b0, REG_LEPTON_ID, 0, 1'b1, 0, 0, 15, 5, 1'b1, 1'b1, 0, 1'b1},
		'{1'b0, REG_LEPTON_ID, 0, 1'b0, 32767, 12868, 1, -16, 1'b1, 1'b1, NINE, 1'b1},
		'{1'b0, REG_LEPTON_ID, 0, 1'b0, -32768, -12868, 0, 15, 1'b0, 1'b0, 0, 1'b0},
		'{1'b0, REG_LEPTON_ID, 0, 1'b1, 32767, 12868, -127, 15, 1'b1, 1'b1, NINE, 1'b0},
		'{1'b0, REG_LEPTON_ID, 0, 1'b0, 0, 0, 127, 0, 1'b1, 1'b1, NINE, 1'b1},
		'{1'b0, REG_LEPTON_ID, 0, 1'b0, 0, 0, -1, 0, 1'b0, 1'b0, 0, 1'b0},
		'{1'b0, REG_LEPTON_ID, 0, 1'b1, 0, 0, 15, 2, 1'b1, 1'b1, NINE, 1'b1},
		'{1'b0, REG_LEPTON_ID, 0, 1'b0, 100, 12868, 1, 0, 1'b0, 1'b0, 0, 1'b0},
		'{1'b0, REG_LEPTON_ID, 0, 1'b1, 100, -12868, -15, 3, 1'b1, 1'b1, 0, 1'b0},
		'{1'b0, REG_LEPTON_ID, 0, 1'b0, 0, 0, 0, 0, 1'b0, 1'b0, 0, 1'b0},
		'{1'b0, REG_LEPTON_ID, 0, 1'b1, 0, 12868, 11, 7, 1'b1, 1'b1, 165585424, 1'b0},
		'{1'b0, REG_LEPTON_ID, 0, 1'b0, -40, -16384, -1, 0, 1'b0, 1'b0, 0, 1'b0},
		'{1'b0, REG_LEPTON_ID, 0, 1'b1, 1000, 16383, -15, 4, 1'b0, 1'b0, 0, 1'b0},
		'{1'b0, REG_LEPTON_ID, 0, 1'b1, -40, 16383, 15, 9, 1'b0, 1'b0, 0, 1'b0},
		'{1'b0, REG_LEPTON_ID, 0, 1'b1, -40, 16383, -15, 9, 1'b1, 1'b0, 0, 1'b0},
		'{1'b0, REG_LEPTON_ID, 0, 1'b1, 5, -5, 0, -16, 1'b1, 1'b0, 0, 1'b0},
		'{1'b1, REG_LEPTON_ID, 0, 1'b0, 7, 7, 1, 0, 1'b0, 1'b0, 0, 1'b0},
		'{1'b0, REG_LEPTON_ID, 0, 1'b1, 7, 7, 0, 3, 1'b1, 1'b1, 0, 1'b0},
		'{1'b0, REG_LEPTON_ID, 0, 1'b1, 8, 9, 5, 15, 1'b1, 1'b0, 0, 1'b0}
	};

	localparam reg_set_t REG_SETS [8] = '{
		'{15, 1, 3}, '{11, 0, -16}, '{13, 1, 15}, '{127, 1, -16},
		'{1, 1, 0}, '{0, 0, -1}, '{15, 1, 3}, '{11, 1, -5}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int cycle_cnt = 0;
	int err_cnt = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	match_res_t match_results_due [$];

	// Model state and its copy of the registers
	logic [6:0]        cfg_lid = 7'd15;
	logic              cfg_skip = 1'b1;
	logic signed [4:0] cfg_min_dm = 5'sd3;
	int                rec_eta = 0;
	int                rec_phi = 0;
	int                rec_chg = 0;
	longint            best_d = longint'(NINE);
	int                best_chg = 0;
	int                run_chg = 0;

	nearest_delta_r_charge_matcher_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int pick(input int lo, input int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic match_req_t make_req(input bit req_type, input int eta, input int phi,
			input int id_code, input int decay_mode, input bit last);
		match_req_t r;
		r.req_type   = req_type;
		r.eta        = 16'(eta);
		r.phi        = 15'(phi);
		r.id_code    = 8'(id_code);
		r.decay_mode = 5'(decay_mode);
		r.last       = last;
		return r;
	endfunction

	// Advances the match state by one request; returns 1 when a result is due.
	function automatic bit predict_match(input match_req_t r, output match_res_t res);
		int     deta;
		int     dphi;
		longint d;
		if (!r.req_type) begin
			rec_eta  = int'(r.eta);
			rec_phi  = int'(r.phi);
			rec_chg  = (r.id_code >= -1 && r.id_code <= 1) ? int'(r.id_code) : -2;
			best_d   = longint'(NINE);
			best_chg = 0;
			run_chg  = 0;
		end else if (!(cfg_skip && r.decay_mode < cfg_min_dm)) begin
			// With an id of zero both checks hit and the positive charge wins.
			if (int'(r.id_code) == int'(cfg_lid))
				run_chg = -1;
			if (int'(r.id_code) == -int'(cfg_lid))
				run_chg = 1;
			deta = int'(r.eta) - rec_eta;
			dphi = int'(r.phi) - rec_phi;
			if (dphi >= PI_I)
				dphi -= TWO_PI_I;
			else if (dphi < -PI_I)
				dphi += TWO_PI_I;
			d = longint'(deta) * deta + longint'(dphi) * dphi;
			if (d > longint'(DIST_MAX))
				d = longint'(DIST_MAX);
			if (d < best_d) begin
				best_d   = d;
				best_chg = run_chg;
			end
		end
		res.dist_sq         = 31'(best_d);
		res.charge_mismatch = (rec_chg != best_chg);
		return r.last;
	endfunction

	task automatic send_req(input match_req_t r, input bit typed, input match_res_t typed_res);
		match_res_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.req_type;
		s_tlast  <= r.last;
		s_tdata  <= {4'd0, r.decay_mode, r.id_code, r.phi, r.eta};
		do @(posedge clk); while (!s_tready);
		if (predict_match(r, res))
			match_results_due.push_back(typed ? typed_res : res);
	endtask

	// Waits until every due result has arrived and the pipeline has emptied.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (match_results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_LEPTON_ID:      cfg_lid = val[6:0];
			REG_SKIP_ENABLE:    cfg_skip = val[0];
			REG_MIN_DECAY_MODE: cfg_min_dm = val[4:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		match_res_t due;
		if (m_tvalid && m_tready) begin
			if (match_results_due.size() == 0) begin
				$error("result with none due: dist_sq %0d, charge_mismatch %0d",
					m_tdata[30:0], m_tdata[31]);
				err_cnt++;
			end else begin
				due = match_results_due.pop_front();
				if (m_tdata[30:0] !== due.dist_sq) begin
					$error("dist_sq: expected %0d, actual %0d", due.dist_sq, m_tdata[30:0]);
					err_cnt++;
				end
				if (m_tdata[31] !== due.charge_mismatch) begin
					$error("charge_mismatch: expected %0d, actual %0d",
						due.charge_mismatch, m_tdata[31]);
					err_cnt++;
				end
			end
		end
		m_tready <= ($urandom_range(0, 99) < recv_stall_pct) ? 1'b0 : 1'b1;
	end

	initial begin
		dir_row_t   row;
		match_res_t typed_res;
		int         n;
		int         ngen;
		int         anchor;
		int         eta_i;
		int         phi_i;
		int         id_i;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i]) begin
			row = DIR_ROWS[i];
			if (row.wr) begin
				settle();
				write_reg(row.wr_reg, 32'(row.wr_val));
			end
			typed_res.dist_sq         = 31'(row.dist_sq);
			typed_res.charge_mismatch = row.charge_mismatch;
			send_req(make_req(row.req_type, row.eta, row.phi, row.id_code, row.decay_mode,
				row.last), row.typed, typed_res);
		end

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			write_reg(REG_LEPTON_ID, 32'(REG_SETS[ph].lid));
			write_reg(REG_SKIP_ENABLE, 32'(REG_SETS[ph].skip));
			write_reg(REG_MIN_DECAY_MODE, 32'(REG_SETS[ph].min_dm));
			n = 0;
			while (n < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 85) begin
					// A reco request followed by a run of gen candidates around it.
					anchor = pick(-32768, 32767);
					phi_i  = pick(-12868, 12868);
					id_i   = ($urandom_range(0, 4) == 0) ? pick(-127, 127) : pick(-1, 1);
					send_req(make_req(1'b0, anchor, phi_i, id_i, pick(-16, 15),
						$urandom_range(0, 19) == 0), 1'b0, typed_res);
					n++;
					ngen = pick(1, 8);
					for (int k = 0; k < ngen; k++) begin
						eta_i = ($urandom_range(0, 9) == 0) ? pick(-32768, 32767)
							: anchor + pick(-8000, 8000);
						phi_i = ($urandom_range(0, 9) == 0) ? pick(-16384, 16383)
							: pick(-12868, 12868);
						case ($urandom_range(0, 3))
							0: id_i = int'(cfg_lid);
							1: id_i = -int'(cfg_lid);
							default: id_i = pick(-127, 127);
						endcase
						send_req(make_req(1'b1, eta_i, phi_i, id_i, pick(-16, 15),
							k == ngen - 1), 1'b0, typed_res);
						n++;
					end
				end else begin
					send_req(make_req(1'($urandom_range(0, 1)), pick(-32768, 32767),
						pick(-16384, 16383), pick(-127, 127), pick(-16, 15),
						1'($urandom_range(0, 1))), 1'b0, typed_res);
					n++;
				end
			end
		end

		settle();
		if (err_cnt == 0 && match_results_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
